// ===== hw/rtl/ldss_pkg.sv =====
// ----------------------------------------------------------------------------
// ldss_pkg: shared types for the LOOK / C-LOOK seek scheduler
// Field structs of the request and result channels, and register indexes.
// ----------------------------------------------------------------------------
package ldss_pkg;

    localparam int TRACK_W = 12;
    localparam int SEEK_W  = 20;
    localparam logic [SEEK_W-1:0] SEEK_MAX = 20'hFFFFF;

    localparam logic [0:0] REG_SCHED_MODE = 1'b0;
    localparam logic [0:0] REG_START_HEAD = 1'b1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    typedef struct packed {
        logic [TRACK_W-1:0] request_track;
        logic               last_request;
    } req_item_t;

    typedef struct packed {
        logic [TRACK_W-1:0] served_track;
        logic [SEEK_W-1:0]  seek_sum;
        logic               final_move;
    } res_item_t;

endpackage

// ===== hw/rtl/ldss_seek_acc.sv =====
// ----------------------------------------------------------------------------
// ldss_seek_acc: seek distance accumulator
// Adds the distance from the head to a new track and saturates the total.
// ----------------------------------------------------------------------------
module ldss_seek_acc (
    input  logic [ldss_pkg::TRACK_W-1:0] head,
    input  logic [ldss_pkg::TRACK_W-1:0] track,
    input  logic [ldss_pkg::SEEK_W-1:0]  acc,
    output logic [ldss_pkg::SEEK_W-1:0]  acc_out
);
    import ldss_pkg::*;

    logic [TRACK_W-1:0] distance;
    logic [SEEK_W:0]    sum;

    always_comb begin
        distance = (track >= head) ? track - head : head - track;
        sum  = {1'b0, acc} + {{(SEEK_W + 1 - TRACK_W){1'b0}}, distance};
        acc_out = sum[SEEK_W] ? SEEK_MAX : sum[SEEK_W-1:0];
    end
endmodule

// ===== hw/rtl/look_disk_seek_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// look_disk_seek_scheduler_unit: LOOK / C-LOOK disk seek scheduler
// Collects a batch of track requests and emits them in sweep order.
// ----------------------------------------------------------------------------
// Requests load one per cycle into an internal store, except while a result
// still waits for m_ready. The item marked last starts the walk: each served
// result is found by one scan over the stored requests, one entry per cycle,
// followed by a read state and an emit state; the emit state holds while the
// previous result still waits for m_ready. The next batch is accepted once
// the walk is done and the last result has been taken.
// Each scan selects the smallest not yet served entry at or above the start
// (upward part), or for the remaining part the largest below the start (LOOK)
// or the smallest below the start (C-LOOK); ties go to the lowest index.
module look_disk_seek_scheduler_unit #(
    parameter int MAX_REQUESTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ldss_pkg::req_item_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ldss_pkg::res_item_t           m_data,
    input  logic                          cfg_we,
    input  logic [ldss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ldss_pkg::*;

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_READ = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic               mode_reg;
    logic [TRACK_W-1:0] start_reg;
    logic [TRACK_W-1:0] store_mem [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] served_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   left_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic [TRACK_W-1:0] head_reg;
    logic [SEEK_W-1:0]  acc_reg;
    logic               upper_found_reg;
    logic               found_reg;
    logic [TRACK_W-1:0] best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [TRACK_W-1:0] rd_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_live_reg;
    logic               walk_mode_reg;
    logic [TRACK_W-1:0] walk_start_reg;
    res_item_t          out_reg;
    logic               out_valid_reg;
    logic [SEEK_W-1:0]  acc_new;

    ldss_seek_acc u_acc (
        .head(head_reg), .track(best_reg), .acc(acc_reg), .acc_out(acc_new)
    );

    assign s_ready = (state_reg == ST_LOAD) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Candidate test for the registered read of one stored entry.
    logic cand_up, cand_lo, better;
    always_comb begin
        cand_up = rd_live_reg && (rd_reg >= walk_start_reg);
        cand_lo = rd_live_reg && (rd_reg < walk_start_reg);
        better  = 1'b0;
        if (cand_up) begin
            better = !upper_found_reg || !found_reg || (rd_reg < best_reg);
        end else if (cand_lo && !upper_found_reg) begin
            if (!found_reg) better = 1'b1;
            else if (walk_mode_reg) better = rd_reg < best_reg;
            else better = rd_reg > best_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (s_valid && s_ready && s_data.last_request) state_next = ST_SCAN;
            ST_SCAN: if (scan_reg == count_reg) state_next = ST_READ;
            ST_READ: state_next = ST_EMIT;
            ST_EMIT: if (!out_valid_reg)
                state_next = (left_reg == CNT_W'(1)) ? ST_LOAD : ST_SCAN;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && count_reg < CNT_W'(MAX_REQUESTS))
            store_mem[count_reg[IDX_W-1:0]] <= s_data.request_track;
        if (state_reg == ST_SCAN && scan_reg < count_reg)
            rd_reg <= store_mem[scan_reg[IDX_W-1:0]];
        rd_idx_reg <= scan_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            mode_reg      <= 1'b0;
            start_reg     <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            scan_reg      <= '0;
            head_reg      <= '0;
            acc_reg       <= '0;
            served_reg    <= '0;
            found_reg     <= 1'b0;
            upper_found_reg <= 1'b0;
            rd_live_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            walk_mode_reg <= 1'b0;
            walk_start_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == REG_SCHED_MODE) mode_reg <= cfg_data[0];
                else if (cfg_index == REG_START_HEAD) start_reg <= cfg_data[TRACK_W-1:0];
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_valid && s_ready) begin
                        logic [CNT_W-1:0] n;
                        n = (count_reg < CNT_W'(MAX_REQUESTS)) ? count_reg + 1'b1 : count_reg;
                        count_reg <= n;
                        if (s_data.last_request) begin
                            left_reg       <= n;
                            walk_mode_reg  <= mode_reg;
                            walk_start_reg <= start_reg;
                            head_reg       <= start_reg;
                            acc_reg        <= '0;
                            served_reg     <= '0;
                            scan_reg       <= '0;
                            found_reg      <= 1'b0;
                            upper_found_reg <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    // The cycle after the last entry carries no live read.
                    rd_live_reg <= (scan_reg < count_reg) &&
                                   !served_reg[scan_reg[IDX_W-1:0]];
                    if (scan_reg < count_reg) begin
                        scan_reg    <= scan_reg + 1'b1;
                    end
                end
                ST_READ: ;
                ST_EMIT: begin
                    if (!out_valid_reg) begin
                        served_reg[best_idx_reg] <= 1'b1;
                        out_reg.served_track <= best_reg;
                        out_reg.seek_sum     <= acc_new;
                        out_reg.final_move   <= (left_reg == CNT_W'(1));
                        out_valid_reg <= 1'b1;
                        acc_reg   <= acc_new;
                        head_reg  <= best_reg;
                        left_reg  <= left_reg - 1'b1;
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        upper_found_reg <= 1'b0;
                        if (left_reg == CNT_W'(1)) count_reg <= '0;
                    end
                end
                default: ;
            endcase
            // Fold in the entry read in the previous cycle.
            if (state_reg != ST_EMIT && better) begin
                found_reg    <= 1'b1;
                best_reg     <= rd_reg;
                best_idx_reg <= rd_idx_reg;
                if (cand_up) upper_found_reg <= 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_REQUESTS)) else $error("request count overflow");
    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= count_reg) else $error("remaining results exceed stored requests");
    a_no_load_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_LOAD |-> !s_ready) else $error("input taken during walk");
    a_emit_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !out_valid_reg) |-> found_reg)
        else $error("emitting without a selected request");
`endif
endmodule
